/* design/smf_pkg.sv */
// ----------------------------------------------------------------------------
// smf_pkg
// Shared constants and types of the three-axis sliding median filter.
// ----------------------------------------------------------------------------
package smf_pkg;

    localparam int WINDOW  = 5;
    localparam int AXES    = 3;
    localparam int DATA_W  = 16;
    localparam int RANK_W  = $clog2(WINDOW);
    localparam bit IS_ODD  = (WINDOW % 2) != 0;

    localparam logic [RANK_W-1:0] HI_RANK = RANK_W'(WINDOW / 2);
    localparam logic [RANK_W-1:0] LO_RANK = IS_ODD ? RANK_W'(WINDOW / 2)
                                                   : RANK_W'(WINDOW / 2 - 1);

    typedef logic signed [DATA_W-1:0] smf_data_t;

    typedef struct packed {
        smf_data_t lo;
        smf_data_t hi;
    } smf_pair_t;

    typedef struct packed {
        logic shift_en;
        logic load_en;
    } smf_ctrl_t;

endpackage

/* design/smf_if.sv */
// ----------------------------------------------------------------------------
// smf_sample_if / smf_median_if
// Valid/ready channels carrying one three-axis sample or one median result.
// ----------------------------------------------------------------------------
interface smf_sample_if;
    import smf_pkg::*;

    logic      valid;
    logic      ready;
    smf_data_t x_sample;
    smf_data_t y_sample;
    smf_data_t z_sample;

    modport source (output valid, output x_sample, output y_sample, output z_sample,
                    input ready);
    modport sink   (input valid, input x_sample, input y_sample, input z_sample,
                    output ready);
endinterface

interface smf_median_if;
    import smf_pkg::*;

    logic      valid;
    logic      ready;
    smf_data_t x_median;
    smf_data_t y_median;
    smf_data_t z_median;

    modport source (output valid, output x_median, output y_median, output z_median,
                    input ready);
    modport sink   (input valid, input x_median, input y_median, input z_median,
                    output ready);
endinterface

/* design/smf_lane.sv */
// ----------------------------------------------------------------------------
// smf_lane
// One axis: sample history and rank-based selection of the middle values.
// ----------------------------------------------------------------------------
module smf_lane
    import smf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  smf_ctrl_t ctrl,
    input  smf_data_t sample,
    output smf_pair_t pair
);

    smf_data_t         hist_reg [WINDOW];
    logic [RANK_W-1:0] rank     [WINDOW];
    smf_pair_t         pair_reg;
    smf_pair_t         pair_next;

    function automatic logic [RANK_W-1:0] count_ones(input logic [WINDOW-1:0] bits);
        logic [RANK_W-1:0] acc;
        acc = '0;
        for (int k = 0; k < WINDOW; k++)
        begin
            acc = acc + RANK_W'(bits[k]);
        end
        return acc;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else if (ctrl.shift_en)
        begin
            hist_reg[0] <= sample;
            for (int i = 1; i < WINDOW; i++)
            begin
                hist_reg[i] <= hist_reg[i-1];
            end
        end
    end

    // rank = number of entries ordered ahead; equal values ordered by position
    always_comb
    begin
        logic [WINDOW-1:0] ahead;
        for (int i = 0; i < WINDOW; i++)
        begin
            ahead = '0;
            for (int j = 0; j < WINDOW; j++)
            begin
                if (j != i)
                begin
                    ahead[j] = (hist_reg[j] < hist_reg[i]) ||
                               ((hist_reg[j] == hist_reg[i]) && (j < i));
                end
            end
            rank[i] = count_ones(ahead);
        end
    end

    always_comb
    begin
        pair_next.lo = '0;
        pair_next.hi = '0;
        for (int i = 0; i < WINDOW; i++)
        begin
            if (rank[i] == LO_RANK)
            begin
                pair_next.lo = hist_reg[i];
            end
            if (rank[i] == HI_RANK)
            begin
                pair_next.hi = hist_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_en)
        begin
            pair_reg <= pair_next;
        end
    end

    assign pair = pair_reg;

endmodule

/* design/smf_merge.sv */
// ----------------------------------------------------------------------------
// smf_merge
// Combines the lane results into one median item and holds it for the sink.
// ----------------------------------------------------------------------------
module smf_merge
    import smf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load_en,
    input  logic      valid_in,
    input  smf_pair_t pairs [AXES],
    output logic      valid,
    output smf_data_t medians [AXES]
);

    logic      valid_reg;
    smf_data_t med_reg  [AXES];
    smf_data_t med_next [AXES];

    always_comb
    begin
        logic signed [DATA_W:0] sum;
        for (int a = 0; a < AXES; a++)
        begin
            sum = {pairs[a].lo[DATA_W-1], pairs[a].lo} + {pairs[a].hi[DATA_W-1], pairs[a].hi};
            if (IS_ODD)
            begin
                med_next[a] = pairs[a].lo;
            end
            else
            begin
                med_next[a] = sum[DATA_W:1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load_en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            med_reg <= med_next;
        end
    end

    assign valid   = valid_reg;
    assign medians = med_reg;

endmodule

/* design/sliding_median_filter_3axis_unit.sv */
// ----------------------------------------------------------------------------
// sliding_median_filter_3axis_unit
// Three-axis sliding-window median filter, one lane per axis.
// ----------------------------------------------------------------------------
// Usage:
//   in  : one x/y/z sample per transaction (signed 16-bit each).
//   out : one x/y/z median per transaction, in input order.
//   Each axis keeps the last WINDOW samples; every accepted sample yields
//   the median of its axis window (odd window: middle value, even window:
//   floor of the mean of the two middle values).
//   Registers from input transaction to out.valid: history shift,
//   rank selection in the lanes, merge/output register.
//   Throughput: one transaction per cycle while out is not stalled; all three
//   lanes compare their WINDOW entries in parallel, combinationally.
//   Reset: histories clear to zero, so the first WINDOW-1 results count
//   those zeros; the pipeline empties and out.valid drops.
//   Stall: while out.valid is high and out.ready low the whole pipeline
//   holds and in.ready is low; in.ready does not wait for an idle state.
// ----------------------------------------------------------------------------
module sliding_median_filter_3axis_unit
    import smf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    smf_sample_if.sink        in,
    smf_median_if.source      out
);

    logic      adv;
    logic      valid_a_reg;
    logic      valid_b_reg;
    logic      out_valid;
    smf_ctrl_t ctrl;
    smf_data_t samples [AXES];
    smf_pair_t pairs   [AXES];
    smf_data_t medians [AXES];

    assign adv           = !out_valid || out.ready;
    assign ctrl.shift_en = in.valid && adv;
    assign ctrl.load_en  = adv;

    assign samples[0] = in.x_sample;
    assign samples[1] = in.y_sample;
    assign samples[2] = in.z_sample;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_a_reg <= in.valid;
            valid_b_reg <= valid_a_reg;
        end
    end

    for (genvar a = 0; a < AXES; a++)
    begin : g_lane
        smf_lane u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctrl   (ctrl),
            .sample (samples[a]),
            .pair   (pairs[a])
        );
    end

    smf_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .load_en  (adv),
        .valid_in (valid_b_reg),
        .pairs    (pairs),
        .valid    (out_valid),
        .medians  (medians)
    );

    assign in.ready     = adv;
    assign out.valid    = out_valid;
    assign out.x_median = medians[0];
    assign out.y_median = medians[1];
    assign out.z_median = medians[2];

endmodule

/* design/smf_checker.sv */
// ----------------------------------------------------------------------------
// smf_checker
// Port-level checks of the median filter, bound to the top level.
// ----------------------------------------------------------------------------
module smf_checker
    import smf_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input smf_data_t x_median,
    input smf_data_t y_median,
    input smf_data_t z_median
);

    a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(x_median) &&
                                    $stable(y_median) && $stable(z_median))
        else $error("stalled result transaction changed or dropped");

    a_ready_only_on_stall : assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input not ready without an output stall");

    a_empty_after_reset : assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result transaction present straight after reset");

    a_no_early_result : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) ##1 1'b1 |-> !out_valid)
        else $error("result transaction without a preceding input");

endmodule

bind sliding_median_filter_3axis_unit smf_checker u_smf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in.ready),
    .out_valid (out.valid),
    .out_ready (out.ready),
    .x_median  (out.x_median),
    .y_median  (out.y_median),
    .z_median  (out.z_median)
);

/* tb/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the three-axis sliding median filter. A queue of
// directed and random samples feeds a clocked driver. A clocked monitor keeps
// its own per-axis window history, works out the median of every accepted
// sample and compares each result transaction in order. Both sides stall at
// random in two phases of differing pressure and not at all in a third.
// ----------------------------------------------------------------------------
module tb;
    import smf_pkg::*;

    localparam int RANDOM_ITEMS = 800;
    localparam int IDLE_LIMIT   = 5000;
    localparam int TAIL_CYCLES  = 8;

    typedef struct {
        smf_data_t x;
        smf_data_t y;
        smf_data_t z;
    } triple_t;

    logic clk;
    logic rst_n;

    smf_sample_if sample_ch ();
    smf_median_if median_ch ();

    sliding_median_filter_3axis_unit u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .in    (sample_ch),
        .out   (median_ch)
    );

    triple_t   pending_samples[$];
    triple_t   expected_medians[$];
    smf_data_t axis_history[AXES][WINDOW];
    int        total_items;
    int        accepted_cnt;
    int        error_cnt;
    int        idle_cycles;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int stress_phase(input int done);
        if (done < total_items / 3)
            return 0;
        else if (done < (2 * total_items) / 3)
            return 1;
        else
            return 2;
    endfunction

    function automatic smf_data_t axis_median(input int axis);
        smf_data_t             sorted_w[WINDOW];
        smf_data_t             v;
        logic signed [DATA_W:0] pair_sum;
        int                    j;
        for (int i = 0; i < WINDOW; i++)
        begin
            v = axis_history[axis][i];
            j = i;
            while (j > 0 && sorted_w[j - 1] > v)
            begin
                sorted_w[j] = sorted_w[j - 1];
                j--;
            end
            sorted_w[j] = v;
        end
        if (IS_ODD)
            return sorted_w[WINDOW / 2];
        pair_sum = {sorted_w[WINDOW / 2 - 1][DATA_W-1], sorted_w[WINDOW / 2 - 1]}
                 + {sorted_w[WINDOW / 2][DATA_W-1], sorted_w[WINDOW / 2]};
        return pair_sum[DATA_W:1];
    endfunction

    task automatic shift_and_predict(input smf_data_t xs, input smf_data_t ys,
                                     input smf_data_t zs);
        triple_t   med;
        smf_data_t fresh[AXES];
        fresh[0] = xs;
        fresh[1] = ys;
        fresh[2] = zs;
        for (int a = 0; a < AXES; a++)
        begin
            for (int i = WINDOW - 1; i > 0; i--)
                axis_history[a][i] = axis_history[a][i - 1];
            axis_history[a][0] = fresh[a];
        end
        med.x = axis_median(0);
        med.y = axis_median(1);
        med.z = axis_median(2);
        expected_medians.push_back(med);
    endtask

    task automatic check_median(input smf_data_t xm, input smf_data_t ym,
                                input smf_data_t zm);
        triple_t want;
        if (expected_medians.size() == 0)
        begin
            $error("median transaction with nothing pending: x %0d y %0d z %0d",
                   xm, ym, zm);
            error_cnt++;
            return;
        end
        want = expected_medians.pop_front();
        if (xm !== want.x)
        begin
            $error("x_median mismatch: expected %0d, actual %0d", want.x, xm);
            error_cnt++;
        end
        if (ym !== want.y)
        begin
            $error("y_median mismatch: expected %0d, actual %0d", want.y, ym);
            error_cnt++;
        end
        if (zm !== want.z)
        begin
            $error("z_median mismatch: expected %0d, actual %0d", want.z, zm);
            error_cnt++;
        end
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        triple_t nxt;
        int      pct;
        if (!rst_n)
        begin
            sample_ch.valid    <= 1'b0;
            sample_ch.x_sample <= '0;
            sample_ch.y_sample <= '0;
            sample_ch.z_sample <= '0;
        end
        else if (!sample_ch.valid || sample_ch.ready)
        begin
            case (stress_phase(accepted_cnt))
                0:       pct = 30;
                1:       pct = 78;
                default: pct = 0;
            endcase
            if (pending_samples.size() != 0 && $urandom_range(99) >= pct)
            begin
                nxt = pending_samples.pop_front();
                sample_ch.valid    <= 1'b1;
                sample_ch.x_sample <= nxt.x;
                sample_ch.y_sample <= nxt.y;
                sample_ch.z_sample <= nxt.z;
            end
            else
            begin
                sample_ch.valid <= 1'b0;
            end
        end
    end

    // monitor and predictor
    always @(posedge clk or negedge rst_n)
    begin
        int pct;
        if (!rst_n)
        begin
            median_ch.ready <= 1'b0;
            accepted_cnt    <= 0;
            for (int a = 0; a < AXES; a++)
                for (int i = 0; i < WINDOW; i++)
                    axis_history[a][i] = '0;
        end
        else
        begin
            if (median_ch.valid && median_ch.ready)
                check_median(median_ch.x_median, median_ch.y_median, median_ch.z_median);
            if (sample_ch.valid && sample_ch.ready)
            begin
                shift_and_predict(sample_ch.x_sample, sample_ch.y_sample,
                                  sample_ch.z_sample);
                accepted_cnt <= accepted_cnt + 1;
            end
            case (stress_phase(accepted_cnt))
                0:       pct = 78;
                1:       pct = 30;
                default: pct = 0;
            endcase
            median_ch.ready <= ($urandom_range(99) >= pct);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (sample_ch.valid && sample_ch.ready)
            || (median_ch.valid && median_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic queue_sample(input int xs, input int ys, input int zs);
        triple_t s;
        s.x = smf_data_t'(xs);
        s.y = smf_data_t'(ys);
        s.z = smf_data_t'(zs);
        pending_samples.push_back(s);
    endtask

    function automatic smf_data_t random_reading();
        case ($urandom_range(9))
            0, 1, 2, 3: return smf_data_t'($urandom_range(16'hFFFF));
            4, 5:       return smf_data_t'(int'($urandom_range(8)) - 4);
            6:          return $urandom_range(1) ? smf_data_t'(32767) : smf_data_t'(-32768);
            7:          return smf_data_t'(32767 - int'($urandom_range(3)));
            8:          return smf_data_t'(-32768 + int'($urandom_range(3)));
            default:    return smf_data_t'(int'($urandom_range(200)) - 100);
        endcase
    endfunction

    initial
    begin
        triple_t s;
        clk                = 1'b0;
        rst_n              = 1'b0;
        sample_ch.valid    = 1'b0;
        sample_ch.x_sample = '0;
        sample_ch.y_sample = '0;
        sample_ch.z_sample = '0;
        median_ch.ready    = 1'b0;
        error_cnt          = 0;
        idle_cycles        = 0;
        accepted_cnt       = 0;

        // early outputs still see the zeroed history
        queue_sample(32767, -32768, 0);
        queue_sample(-32768, 32767, -1);
        queue_sample(32767, 32767, 32767);
        queue_sample(-32768, -32768, -32768);
        queue_sample(1, -1, 1);
        queue_sample(32767, -32768, -1);
        // ascending, descending and alternating runs
        queue_sample(100, 500, -32768);
        queue_sample(200, 400, 32767);
        queue_sample(300, 300, -32768);
        queue_sample(400, 200, 32767);
        queue_sample(500, 100, -32768);
        // ties
        queue_sample(7, -7, 0);
        queue_sample(7, -7, 0);
        queue_sample(7, -7, 0);
        queue_sample(8, -8, 0);
        queue_sample(6, -6, 0);
        // all extremes together
        queue_sample(32767, 32767, 32767);
        queue_sample(32767, 32767, 32767);
        queue_sample(-32768, -32768, -32768);
        queue_sample(-32768, -32768, -32768);
        queue_sample(-1, 0, 1);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if ($urandom_range(7) == 0 && pending_samples.size() != 0)
            begin
                s = pending_samples[$];
                if ($urandom_range(1))
                    s.x = random_reading();
                pending_samples.push_back(s);
            end
            else
            begin
                s.x = random_reading();
                s.y = random_reading();
                s.z = random_reading();
                pending_samples.push_back(s);
            end
        end
        total_items = pending_samples.size();

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        do
            @(negedge clk);
        while (pending_samples.size() != 0 || sample_ch.valid
               || expected_medians.size() != 0);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (error_cnt == 0 && expected_medians.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
